FILE: hw/rtl/mcsr_pkg.sv
// Shared types and constants for the modifier combo stick resolver.
// Used by mcsr_ctrl, mcsr_dp and the top level; no dependencies.
package mcsr_pkg;

  localparam int ComboSlots = 16;
  localparam int TableSlots = 8;
  localparam int MaskBits   = 8;
  localparam int CoordBits  = 16;
  localparam int DirCount   = 9;

  localparam int ComboIdxW  = $clog2(ComboSlots);
  localparam int TabIdxW    = $clog2(TableSlots);
  localparam int StickDepth = TableSlots * DirCount;
  localparam int StickAw    = $clog2(StickDepth);

  // configuration port
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 8;
  localparam logic [CfgIdxW-1:0] CfgProfileValid = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgIssueCount   = 1'd1;

  typedef enum logic [1:0] {
    CmdResolve  = 2'd0,
    CmdWrCombo  = 2'd1,
    CmdWrStick  = 2'd2,
    CmdSetTable = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    StResolved   = 3'd0,
    StProfileBad = 3'd1,
    StBadDir     = 3'd2,
    StAmbiguous  = 3'd3,
    StNoMatch    = 3'd4,
    StIndexRange = 3'd5,
    StTableOff   = 3'd6,
    StMissing    = 3'd7
  } status_e;

  typedef enum logic [3:0] {
    DgNone       = 4'd0,
    DgValidation = 4'd1,
    DgDirection  = 4'd2,
    DgExactTie   = 4'd3,
    DgExactReq   = 4'd4,
    DgSubsetNone = 4'd5,
    DgSubsetTie  = 4'd6,
    DgComboIdx   = 4'd7,
    DgTableIdx   = 4'd8,
    DgDisabled   = 4'd9,
    DgMissing    = 4'd10
  } diag_e;

  // outcome chosen by the controller, turned into fields by the datapath
  typedef enum logic [3:0] {
    ResOk,
    ResProfile,
    ResDir,
    ResExactTie,
    ResExactReq,
    ResSubNone,
    ResSubTie,
    ResTabIdx,
    ResTabOff,
    ResMissing
  } res_kind_e;

  typedef struct packed {
    cmd_e        command;
    logic [3:0]  slot;
    logic [3:0]  target_table;
    logic        enable_bit;
    logic [7:0]  modifier_mask;
    logic [7:0]  priority_value;
    logic [7:0]  direction;
    logic        present_bit;
    logic [15:0] coordinate_in;
    logic        exact_only;
  } item_t;

  typedef struct packed {
    status_e     status;
    diag_e       diagnostic;
    logic [7:0]  detail;
    logic [3:0]  chosen_combo;
    logic [3:0]  chosen_table;
    logic [15:0] coordinate_out;
  } res_t;

  typedef struct packed {
    logic                on;
    logic [MaskBits-1:0] mods;
    logic [7:0]          prio;
    logic [3:0]          tab;
  } combo_t;

  typedef struct packed {
    logic      wr_item;     // apply a write command from the input item
    logic      capture;     // latch a resolve item
    logic      start_scan;  // clear tracker, rewind scan index
    logic      scan_step;   // test one combo slot
    logic      subset;      // subset match instead of exact
    logic      mem_rd;      // read stick entry of the chosen table
    logic      load_res;    // load output register
    res_kind_e kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic prof_ok;
    logic dir_ok;
    logic exact;
    logic scan_last;
    logic found;
    logic tie;
    logic tab_oob;
    logic tab_off;
    logic present;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: hw/rtl/mcsr_ctrl.sv
// Sequencer for the resolver: accepts items, runs the combo scans and the
// table checks, picks the outcome. Depends on mcsr_pkg.
module mcsr_ctrl import mcsr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  input  cmd_e       item_cmd_i,
  input  dp_stat_t   stat_i,
  output logic       s_tready_o,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    SIdle,
    SCheck,
    SScan,
    SDecide,
    STabCheck,
    SMemWait,
    SEmit
  } state_e;

  state_e    state_q, state_d;
  logic      subset_q, subset_d;
  res_kind_e kind_q, kind_d;
  logic      accept;

  assign s_tready_o = (state_q == SIdle);
  assign accept     = s_tvalid_i && s_tready_o;

  always_comb begin
    state_d  = state_q;
    subset_d = subset_q;
    kind_d   = kind_q;
    cmd_o    = '0;
    cmd_o.subset = subset_q;
    cmd_o.kind   = kind_q;

    case (state_q)
      SIdle: begin
        if (accept) begin
          if (item_cmd_i == CmdResolve) begin
            cmd_o.capture = 1'b1;
            state_d = SCheck;
          end else begin
            cmd_o.wr_item = 1'b1;
          end
        end
      end
      SCheck: begin
        if (!stat_i.prof_ok) begin
          kind_d  = ResProfile;
          state_d = SEmit;
        end else if (!stat_i.dir_ok) begin
          kind_d  = ResDir;
          state_d = SEmit;
        end else begin
          cmd_o.start_scan = 1'b1;
          subset_d = 1'b0;
          state_d  = SScan;
        end
      end
      SScan: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_last) begin
          state_d = SDecide;
        end
      end
      SDecide: begin
        if (stat_i.found && stat_i.tie) begin
          kind_d  = subset_q ? ResSubTie : ResExactTie;
          state_d = SEmit;
        end else if (!stat_i.found) begin
          if (subset_q) begin
            kind_d  = ResSubNone;
            state_d = SEmit;
          end else if (stat_i.exact) begin
            kind_d  = ResExactReq;
            state_d = SEmit;
          end else begin
            cmd_o.start_scan = 1'b1;
            subset_d = 1'b1;
            state_d  = SScan;
          end
        end else begin
          state_d = STabCheck;
        end
      end
      STabCheck: begin
        if (stat_i.tab_oob) begin
          kind_d  = ResTabIdx;
          state_d = SEmit;
        end else if (stat_i.tab_off) begin
          kind_d  = ResTabOff;
          state_d = SEmit;
        end else begin
          cmd_o.mem_rd = 1'b1;
          state_d = SMemWait;
        end
      end
      SMemWait: begin
        kind_d  = stat_i.present ? ResOk : ResMissing;
        state_d = SEmit;
      end
      SEmit: begin
        if (stat_i.out_free) begin
          cmd_o.load_res = 1'b1;
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      subset_q <= 1'b0;
      kind_q   <= ResOk;
    end else begin
      state_q  <= state_d;
      subset_q <= subset_d;
      kind_q   <= kind_d;
    end
  end

endmodule

FILE: hw/rtl/mcsr_dp.sv
// Datapath of the resolver: combo store, table enables, stick entry memory,
// scan tracker, config registers and output register. Depends on mcsr_pkg.
module mcsr_dp import mcsr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  item_t               item_i,
  input  ctrl_cmd_t           cmd_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                m_tready_i,
  output dp_stat_t            stat_o,
  output logic                m_tvalid_o,
  output res_t                res_o
);

  // configuration
  logic       prof_valid_q;
  logic [7:0] issue_cnt_q;

  // stores
  combo_t                combo_q [ComboSlots];
  logic [TableSlots-1:0] tab_en_q;
  logic [StickDepth-1:0] stick_vld_q;
  logic [CoordBits:0]    stick_mem [StickDepth];  // {present, coord}

  // resolve item
  logic [MaskBits-1:0] act_q;
  logic [7:0]          dir_q;
  logic                exact_q;

  // scan tracker
  logic [ComboIdxW-1:0] scan_idx_q;
  logic                 found_q, tie_q;
  logic [7:0]           best_prio_q;
  logic [ComboIdxW-1:0] best_idx_q;
  logic [3:0]           best_tab_q;

  logic [CoordBits:0] rd_word_q;
  logic               rd_vld_q;

  logic out_valid_q;
  res_t out_q, res_d;

  logic               combo_we, stick_we, tab_we;
  logic [StickAw-1:0] stick_waddr, stick_raddr;
  combo_t             scan_entry;
  logic               match, hit_new, hit_tie;

  // write decode; out-of-range slots are dropped
  assign combo_we = cmd_i.wr_item && (item_i.command == CmdWrCombo)
                    && (32'(item_i.slot) < ComboSlots);
  assign stick_we = cmd_i.wr_item && (item_i.command == CmdWrStick)
                    && (32'(item_i.slot) < TableSlots)
                    && (32'(item_i.direction) < DirCount);
  assign tab_we   = cmd_i.wr_item && (item_i.command == CmdSetTable)
                    && (32'(item_i.slot) < TableSlots);

  assign stick_waddr = StickAw'(32'(item_i.slot) * DirCount + 32'(item_i.direction));
  // key 1..9 maps to entry 0..8
  assign stick_raddr = StickAw'(32'(best_tab_q) * DirCount + 32'(dir_q) - 32'd1);

  assign scan_entry = combo_q[scan_idx_q];
  assign match   = scan_entry.on &&
                   (cmd_i.subset ? ((scan_entry.mods & act_q) == scan_entry.mods)
                                 : (scan_entry.mods == act_q));
  assign hit_new = match && (!found_q || (scan_entry.prio > best_prio_q));
  assign hit_tie = match && found_q && (scan_entry.prio == best_prio_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prof_valid_q <= 1'b0;
      issue_cnt_q  <= '0;
      for (int i = 0; i < ComboSlots; i++) begin
        combo_q[i] <= '0;
      end
      tab_en_q    <= '0;
      stick_vld_q <= '0;
      scan_idx_q  <= '0;
      found_q     <= 1'b0;
      tie_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgProfileValid: prof_valid_q <= cfg_wdata_i[0];
          CfgIssueCount:   issue_cnt_q  <= cfg_wdata_i[7:0];
          default: ;
        endcase
      end
      if (combo_we) begin
        combo_q[item_i.slot[ComboIdxW-1:0]] <= '{
          on:   item_i.enable_bit,
          mods: item_i.modifier_mask[MaskBits-1:0],
          prio: item_i.priority_value,
          tab:  item_i.target_table
        };
      end
      if (tab_we) begin
        tab_en_q[item_i.slot[TabIdxW-1:0]] <= item_i.enable_bit;
      end
      if (stick_we) begin
        stick_vld_q[stick_waddr] <= 1'b1;
      end
      if (cmd_i.start_scan) begin
        scan_idx_q <= '0;
        found_q    <= 1'b0;
        tie_q      <= 1'b0;
      end else if (cmd_i.scan_step) begin
        scan_idx_q <= scan_idx_q + ComboIdxW'(1);
        if (hit_new) begin
          found_q <= 1'b1;
          tie_q   <= 1'b0;
        end else if (hit_tie) begin
          tie_q <= 1'b1;
        end
      end
      if (cmd_i.load_res) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stick_we) begin
      stick_mem[stick_waddr] <= {item_i.present_bit, item_i.coordinate_in[CoordBits-1:0]};
    end
    if (cmd_i.mem_rd) begin
      rd_word_q <= stick_mem[stick_raddr];
      rd_vld_q  <= stick_vld_q[stick_raddr];
    end
    if (cmd_i.capture) begin
      act_q   <= item_i.modifier_mask[MaskBits-1:0];
      dir_q   <= item_i.direction;
      exact_q <= item_i.exact_only;
    end
    if (cmd_i.scan_step && hit_new) begin
      best_prio_q <= scan_entry.prio;
      best_idx_q  <= scan_idx_q;
      best_tab_q  <= scan_entry.tab;
    end
    if (cmd_i.load_res) begin
      out_q <= res_d;
    end
  end

  // result fields for the outcome the controller picked
  always_comb begin
    res_d = '{status: StResolved, diagnostic: DgNone, default: '0};
    case (cmd_i.kind)
      ResProfile: begin
        res_d.status     = StProfileBad;
        res_d.diagnostic = DgValidation;
        res_d.detail     = issue_cnt_q;
      end
      ResDir: begin
        res_d.status     = StBadDir;
        res_d.diagnostic = DgDirection;
        res_d.detail     = dir_q;
      end
      ResExactTie: begin
        res_d.status     = StAmbiguous;
        res_d.diagnostic = DgExactTie;
        res_d.detail     = 8'(act_q);
      end
      ResSubTie: begin
        res_d.status     = StAmbiguous;
        res_d.diagnostic = DgSubsetTie;
        res_d.detail     = 8'(act_q);
      end
      ResExactReq: begin
        res_d.status     = StNoMatch;
        res_d.diagnostic = DgExactReq;
        res_d.detail     = 8'(act_q);
      end
      ResSubNone: begin
        res_d.status     = StNoMatch;
        res_d.diagnostic = DgSubsetNone;
        res_d.detail     = 8'(act_q);
      end
      ResTabIdx: begin
        res_d.status       = StIndexRange;
        res_d.diagnostic   = DgTableIdx;
        res_d.detail       = 8'(best_tab_q);
        res_d.chosen_combo = 4'(best_idx_q);
        res_d.chosen_table = best_tab_q;
      end
      ResTabOff: begin
        res_d.status       = StTableOff;
        res_d.diagnostic   = DgDisabled;
        res_d.detail       = 8'(best_tab_q);
        res_d.chosen_combo = 4'(best_idx_q);
        res_d.chosen_table = best_tab_q;
      end
      ResMissing: begin
        res_d.status       = StMissing;
        res_d.diagnostic   = DgMissing;
        res_d.detail       = dir_q;
        res_d.chosen_combo = 4'(best_idx_q);
        res_d.chosen_table = best_tab_q;
      end
      ResOk: begin
        res_d.chosen_combo   = 4'(best_idx_q);
        res_d.chosen_table   = best_tab_q;
        res_d.coordinate_out = 16'(rd_word_q[CoordBits-1:0]);
      end
      default: ;
    endcase
  end

  assign stat_o.prof_ok   = prof_valid_q;
  assign stat_o.dir_ok    = (dir_q != 8'd0) && (32'(dir_q) <= DirCount);
  assign stat_o.exact     = exact_q;
  assign stat_o.scan_last = (scan_idx_q == ComboIdxW'(ComboSlots - 1));
  assign stat_o.found     = found_q;
  assign stat_o.tie       = tie_q;
  assign stat_o.tab_oob   = (32'(best_tab_q) >= TableSlots);
  assign stat_o.tab_off   = !tab_en_q[best_tab_q[TabIdxW-1:0]];
  assign stat_o.present   = rd_vld_q && rd_word_q[CoordBits];
  assign stat_o.out_free  = !out_valid_q || m_tready_i;

  assign m_tvalid_o = out_valid_q;
  assign res_o      = out_q;

endmodule

FILE: hw/rtl/modifier_combo_stick_resolver.sv
// Top level of the modifier combo stick resolver: stream ports, field
// packing, controller and datapath. Depends on mcsr_pkg, mcsr_ctrl, mcsr_dp.
//
// Holds 16 combo entries (enable, modifier mask, priority, stick table
// index) and 8 stick tables of nine entries each. Input transactions either
// load those stores (tuser command 1 combo entry, 2 stick entry, 3 table
// enable, no output) or resolve a direction key against the active
// modifier mask (command 0, one output transaction). A resolve first
// scans all combo slots for an exact mask match at the highest priority;
// if none and exact_only is clear, it scans again for a subset match. A tie
// at the best priority reports ambiguous. The chosen table is then checked
// for range and enable and its entry read from the stick memory.
// Profile-invalid and bad-direction results are emitted without any combo
// scan. Each scan reads one combo slot per cycle, so the scan length sets
// the rate. The input is not ready while a resolve is in flight; a finished
// result sits in the output register and the next item is taken while it
// waits. Stick entries live in a 72-entry memory with a valid flop per
// entry, cleared at reset, so no clearing pass is needed.
// Configuration (profile_valid at index 0, validation_issue_count at index 1)
// is written through cfg_we_i and may only change while the block is idle.
module modifier_combo_stick_resolver import mcsr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // tdata, low bit up: slot[3:0], target_table[7:4], enable_bit[8],
  // modifier_mask[16:9], priority_value[24:17], direction[32:25],
  // present_bit[33], coordinate_in[49:34], exact_only[50], zero pad
  input  logic [55:0]         s_axis_tdata_i,
  // tuser: command[1:0]
  input  logic [1:0]          s_axis_tuser_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // tdata, low bit up: status[2:0], diagnostic[6:3], detail[14:7],
  // chosen_combo[18:15], chosen_table[22:19], coordinate_out[38:23], zero pad
  output logic [39:0]         m_axis_tdata_o,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  item_t     item;
  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  res_t      res;

  // unpack the input transaction
  assign item.command        = cmd_e'(s_axis_tuser_i);
  assign item.slot           = s_axis_tdata_i[3:0];
  assign item.target_table   = s_axis_tdata_i[7:4];
  assign item.enable_bit     = s_axis_tdata_i[8];
  assign item.modifier_mask  = s_axis_tdata_i[16:9];
  assign item.priority_value = s_axis_tdata_i[24:17];
  assign item.direction      = s_axis_tdata_i[32:25];
  assign item.present_bit    = s_axis_tdata_i[33];
  assign item.coordinate_in  = s_axis_tdata_i[49:34];
  assign item.exact_only     = s_axis_tdata_i[50];

  mcsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .item_cmd_i (item.command),
    .stat_i     (stat),
    .s_tready_o (s_axis_tready_o),
    .cmd_o      (cmd)
  );

  mcsr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .m_tready_i  (m_axis_tready_i),
    .stat_o      (stat),
    .m_tvalid_o  (m_axis_tvalid_o),
    .res_o       (res)
  );

  // pack the output transaction
  assign m_axis_tdata_o = {1'b0, res.coordinate_out, res.chosen_table, res.chosen_combo,
                           res.detail, res.diagnostic, res.status};

endmodule
